>>> hw/rtl/tfop_pkg.sv
package tfop_pkg;

    localparam int COUNT_BITS_DEFAULT = 32;

    localparam logic [7:0] CS_U16 = 8'd253;
    localparam logic [7:0] CS_U32 = 8'd254;
    localparam logic [7:0] CS_U64 = 8'd255;
    localparam logic [7:0] SEGWIT_FLAG = 8'h01;
    localparam logic [7:0] SEGWIT_MARKER = 8'h00;

    localparam int PREFIX_BYTES = 36;
    localparam logic [2:0] VERSION_BYTES = 3'd4;
    localparam logic [2:0] SEQUENCE_BYTES = 3'd4;
    localparam logic [2:0] VALUE_LAST_IDX = 3'd7;

    typedef enum logic [13:0] {
        PH_VERSION  = 14'b00000000000001,
        PH_SEGWIT   = 14'b00000000000010,
        PH_SEGWIT2  = 14'b00000000000100,
        PH_NIN      = 14'b00000000001000,
        PH_INPREFIX = 14'b00000000010000,
        PH_SSLEN    = 14'b00000000100000,
        PH_SSSKIP   = 14'b00000001000000,
        PH_SEQ      = 14'b00000010000000,
        PH_NOUT     = 14'b00000100000000,
        PH_VALUE    = 14'b00001000000000,
        PH_SPKLEN   = 14'b00010000000000,
        PH_SPK      = 14'b00100000000000,
        PH_DONE     = 14'b01000000000000,
        PH_FAIL     = 14'b10000000000000
    } phase_t;

    typedef struct packed {
        logic        has_byte;
        logic [7:0]  spk_byte;
        logic        done_res;
        logic        ok;
        logic [63:0] amount;
        logic [31:0] spk_length;
    } res_t;

    function automatic logic [63:0] lane_or(input logic [63:0] acc, input logic [7:0] b,
                                            input logic [2:0] idx);
        logic [63:0] r;
        r = acc;
        for (int i = 0; i < 8; i++) begin
            if (idx == 3'(i)) begin
                r[8*i +: 8] = acc[8*i +: 8] | b;
            end
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/tx_first_output_parser_core.sv
// Streaming parser for a serialized transaction, one byte word per cycle. Each accepted byte
// updates the parse state in the cycle it is taken, so the parse logic never holds the input
// and a byte can be taken every cycle while the skid register is empty; a result word (a
// scriptPubKey byte, the summary on the byte marked last, or both) is registered into the
// output register while the output is free. The output register is backed by a one-word skid
// register, and in_stall rises only while that skid register is full, so a stalled output
// costs at most one extra word of buffering before the input is held. On the last byte the
// summary carries ok, the first output's amount and its declared script length, and the
// parser returns to its reset state for the next transaction. COUNT_BITS sets the width of
// the input, scriptSig and script counters; a larger count ends the parse with ok low.
module tx_first_output_parser_core
    import tfop_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        has_byte,
    output logic [7:0]  spk_byte,
    output logic        done_res,
    output logic        ok,
    output logic [63:0] amount,
    output logic [31:0] spk_length
);

    phase_t                  phase_reg, phase_next, eph;
    logic [2:0]              idx_reg, idx_next;
    logic [63:0]             vacc_reg, vacc_next;
    logic [3:0]              vleft_reg, vleft_next;
    logic [COUNT_BITS-1:0]   inputs_reg, inputs_next;
    logic [COUNT_BITS-1:0]   skip_reg, skip_next;
    logic [63:0]             value_reg, value_next;
    logic [COUNT_BITS-1:0]   sleft_reg, sleft_next;
    logic [COUNT_BITS-1:0]   slen_reg, slen_next;
    logic                    pok_reg, pok_next;

    logic                    out_valid_reg, out_valid_next;
    logic                    skid_valid_reg, skid_valid_next;
    res_t                    out_reg, out_next;
    res_t                    skid_reg, skid_next;
    res_t                    res;

    logic                    accept, emit, consumed, has;
    logic                    fv_done, fv_over;
    logic [63:0]             fv_val, fv_acc;
    logic [2:0]              fv_idx;
    logic [3:0]              fv_left;
    logic [COUNT_BITS-1:0]   dec_skip, dec_sleft;

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;
    assign dec_skip  = skip_reg - COUNT_BITS'(1);
    assign dec_sleft = sleft_reg - COUNT_BITS'(1);

    // CompactSize reader step
    always_comb
    begin
        fv_done = 1'b0;
        fv_val  = 64'(in_byte);
        fv_acc  = vacc_reg;
        fv_idx  = idx_reg;
        fv_left = vleft_reg;
        if (vleft_reg == 4'd0) begin
            if (in_byte < CS_U16) begin
                fv_done = 1'b1;
            end
            else begin
                fv_acc = '0;
                fv_idx = '0;
                if (in_byte == CS_U16) begin
                    fv_left = 4'd2;
                end
                else if (in_byte == CS_U32) begin
                    fv_left = 4'd4;
                end
                else begin
                    fv_left = 4'd8;
                end
            end
        end
        else begin
            fv_acc  = lane_or(vacc_reg, in_byte, idx_reg);
            fv_idx  = idx_reg + 3'd1;
            fv_left = vleft_reg - 4'd1;
            fv_done = (vleft_reg == 4'd1);
            fv_val  = fv_acc;
        end
        fv_over = (fv_val >> COUNT_BITS) != 64'd0;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        vacc_next   = vacc_reg;
        vleft_next  = vleft_reg;
        inputs_next = inputs_reg;
        skip_next   = skip_reg;
        value_next  = value_reg;
        sleft_next  = sleft_reg;
        slen_next   = slen_reg;
        pok_next    = pok_reg;
        eph         = phase_reg;
        consumed    = 1'b0;
        has         = 1'b0;

        // resolve the held-back zero after the version
        if (phase_reg == PH_SEGWIT) begin
            if (in_byte == SEGWIT_MARKER) begin
                phase_next = PH_SEGWIT2;
                consumed   = 1'b1;
            end
            else begin
                eph        = PH_NIN;
                phase_next = PH_NIN;
            end
        end
        else if (phase_reg == PH_SEGWIT2) begin
            if (in_byte == SEGWIT_FLAG) begin
                phase_next = PH_NIN;
                consumed   = 1'b1;
            end
            else begin
                inputs_next = '0;
                eph         = PH_NOUT;
                phase_next  = PH_NOUT;
            end
        end

        if (!consumed) begin
            unique case (eph)
                PH_VERSION:
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_next == VERSION_BYTES) begin
                        idx_next   = '0;
                        phase_next = PH_SEGWIT;
                    end
                end
                PH_NIN:
                begin
                    vacc_next  = fv_acc;
                    idx_next   = fv_idx;
                    vleft_next = fv_left;
                    if (fv_done) begin
                        if (fv_over) begin
                            phase_next = PH_FAIL;
                        end
                        else begin
                            inputs_next = fv_val[COUNT_BITS-1:0];
                            if (fv_val == 64'd0) begin
                                phase_next = PH_NOUT;
                            end
                            else begin
                                phase_next = PH_INPREFIX;
                                skip_next  = COUNT_BITS'(PREFIX_BYTES);
                            end
                        end
                    end
                end
                PH_INPREFIX:
                begin
                    skip_next = dec_skip;
                    if (dec_skip == '0) begin
                        phase_next = PH_SSLEN;
                    end
                end
                PH_SSLEN:
                begin
                    vacc_next  = fv_acc;
                    idx_next   = fv_idx;
                    vleft_next = fv_left;
                    if (fv_done) begin
                        idx_next = '0;
                        if (fv_over) begin
                            phase_next = PH_FAIL;
                        end
                        else if (fv_val == 64'd0) begin
                            phase_next = PH_SEQ;
                        end
                        else begin
                            skip_next  = fv_val[COUNT_BITS-1:0];
                            phase_next = PH_SSSKIP;
                        end
                    end
                end
                PH_SSSKIP:
                begin
                    skip_next = dec_skip;
                    if (dec_skip == '0) begin
                        idx_next   = '0;
                        phase_next = PH_SEQ;
                    end
                end
                PH_SEQ:
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_next == SEQUENCE_BYTES) begin
                        idx_next    = '0;
                        inputs_next = inputs_reg - COUNT_BITS'(1);
                        if (inputs_next == '0) begin
                            phase_next = PH_NOUT;
                        end
                        else begin
                            phase_next = PH_INPREFIX;
                            skip_next  = COUNT_BITS'(PREFIX_BYTES);
                        end
                    end
                end
                PH_NOUT:
                begin
                    vacc_next  = fv_acc;
                    idx_next   = fv_idx;
                    vleft_next = fv_left;
                    if (fv_done) begin
                        if (fv_val == 64'd0) begin
                            phase_next = PH_FAIL;
                        end
                        else begin
                            idx_next   = '0;
                            value_next = '0;
                            phase_next = PH_VALUE;
                        end
                    end
                end
                PH_VALUE:
                begin
                    value_next = lane_or(value_reg, in_byte, idx_reg);
                    if (idx_reg == VALUE_LAST_IDX) begin
                        idx_next   = '0;
                        phase_next = PH_SPKLEN;
                    end
                    else begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
                PH_SPKLEN:
                begin
                    vacc_next  = fv_acc;
                    idx_next   = fv_idx;
                    vleft_next = fv_left;
                    if (fv_done) begin
                        if (fv_over) begin
                            phase_next = PH_FAIL;
                        end
                        else begin
                            slen_next  = fv_val[COUNT_BITS-1:0];
                            sleft_next = fv_val[COUNT_BITS-1:0];
                            if (fv_val == 64'd0) begin
                                pok_next   = 1'b1;
                                phase_next = PH_DONE;
                            end
                            else begin
                                phase_next = PH_SPK;
                            end
                        end
                    end
                end
                PH_SPK:
                begin
                    has        = 1'b1;
                    sleft_next = dec_sleft;
                    if (dec_sleft == '0) begin
                        pok_next   = 1'b1;
                        phase_next = PH_DONE;
                    end
                end
                PH_SEGWIT, PH_SEGWIT2, PH_DONE, PH_FAIL:
                begin
                end
                default:
                begin
                end
            endcase
        end

        res.has_byte   = has;
        res.spk_byte   = has ? in_byte : 8'd0;
        res.done_res   = last;
        res.ok         = last && (pok_next || phase_next == PH_SPKLEN);
        res.amount     = res.ok ? value_next : 64'd0;
        res.spk_length = (last && pok_next) ? 32'(slen_next) : 32'd0;

        // back to reset state after the last byte
        if (last) begin
            phase_next  = PH_VERSION;
            idx_next    = '0;
            vacc_next   = '0;
            vleft_next  = '0;
            inputs_next = '0;
            skip_next   = '0;
            value_next  = '0;
            sleft_next  = '0;
            slen_next   = '0;
            pok_next    = 1'b0;
        end
    end

    assign emit = accept && (has || last);

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || !out_stall) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else begin
                out_valid_next = emit;
                out_next       = res;
            end
        end
        else if (emit) begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg      <= PH_VERSION;
            idx_reg        <= '0;
            vacc_reg       <= '0;
            vleft_reg      <= '0;
            inputs_reg     <= '0;
            skip_reg       <= '0;
            value_reg      <= '0;
            sleft_reg      <= '0;
            slen_reg       <= '0;
            pok_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else begin
            if (accept) begin
                phase_reg  <= phase_next;
                idx_reg    <= idx_next;
                vacc_reg   <= vacc_next;
                vleft_reg  <= vleft_next;
                inputs_reg <= inputs_next;
                skip_reg   <= skip_next;
                value_reg  <= value_next;
                sleft_reg  <= sleft_next;
                slen_reg   <= slen_next;
                pok_reg    <= pok_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid  = out_valid_reg;
    assign has_byte   = out_reg.has_byte;
    assign spk_byte   = out_reg.spk_byte;
    assign done_res   = out_reg.done_res;
    assign ok         = out_reg.ok;
    assign amount     = out_reg.amount;
    assign spk_length = out_reg.spk_length;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held with empty output register");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last) |=> (phase_reg == PH_VERSION && !pok_reg))
        else $error("parser not restarted after last byte");

    a_last_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last) |=> out_valid_reg)
        else $error("no summary word after last byte");

    a_ok_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.ok) |-> out_reg.done_res)
        else $error("ok raised on a word that is not the summary");

    a_script_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SPK) |-> (sleft_reg != '0))
        else $error("script phase with no bytes left");

endmodule

>>> tb/sv/tb_tx_first_output_parser_core.sv
module tb_tx_first_output_parser_core
    import tfop_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_BITS_DEFAULT) - 64'd1;
    localparam int RANDOM_BYTES = 750;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  in_byte;
    logic        last;
    logic        out_valid;
    logic        out_stall;
    logic        has_byte;
    logic [7:0]  spk_byte;
    logic        done_res;
    logic        ok;
    logic [63:0] amount;
    logic [31:0] spk_length;

    tx_first_output_parser_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .has_byte   (has_byte),
        .spk_byte   (spk_byte),
        .done_res   (done_res),
        .ok         (ok),
        .amount     (amount),
        .spk_length (spk_length)
    );

    phase_t      ps_phase;
    logic [2:0]  ps_idx;
    logic [63:0] ps_cs_acc;
    logic [3:0]  ps_cs_left;
    logic [63:0] ps_inputs;
    logic [63:0] ps_skip;
    logic [63:0] ps_value;
    logic [63:0] ps_spk_left;
    logic [63:0] ps_spk_len;
    logic        ps_ok;

    res_t        pending_words[$];
    logic [7:0]  tx_bytes[$];
    int          fails;
    int          sent_bytes;
    bit          in_quiet;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_parser();
        ps_phase    = PH_VERSION;
        ps_idx      = '0;
        ps_cs_acc   = '0;
        ps_cs_left  = '0;
        ps_inputs   = '0;
        ps_skip     = '0;
        ps_value    = '0;
        ps_spk_left = '0;
        ps_spk_len  = '0;
        ps_ok       = 1'b0;
    endfunction

    function automatic bit cs_feed(input logic [7:0] b, output logic [63:0] v);
        v = '0;
        if (ps_cs_left == 4'd0)
        begin
            if (b < CS_U16)
            begin
                v = {56'd0, b};
                return 1'b1;
            end
            ps_cs_left = (b == CS_U16) ? 4'd2 : (b == CS_U32) ? 4'd4 : 4'd8;
            ps_cs_acc  = '0;
            ps_idx     = '0;
            return 1'b0;
        end
        ps_cs_acc  = ps_cs_acc | ({56'd0, b} << (8 * ps_idx));
        ps_idx     = ps_idx + 3'd1;
        ps_cs_left = ps_cs_left - 4'd1;
        if (ps_cs_left == 4'd0)
        begin
            v = ps_cs_acc;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void enter_inputs_or_outputs();
        if (ps_inputs == 64'd0)
        begin
            ps_phase = PH_NOUT;
        end
        else
        begin
            ps_phase = PH_INPREFIX;
            ps_skip  = 64'(PREFIX_BYTES);
        end
    endfunction

    function automatic void step_parser(input logic [7:0] b, input logic fin,
                                        output bit emit, output res_t r);
        bit          used;
        bit          has;
        bit          fed;
        logic [63:0] v;
        used = 1'b0;
        has  = 1'b0;
        v    = '0;
        if (ps_phase == PH_SEGWIT)
        begin
            if (b == SEGWIT_MARKER)
            begin
                ps_phase = PH_SEGWIT2;
                used     = 1'b1;
            end
            else
            begin
                ps_phase = PH_NIN;
            end
        end
        else if (ps_phase == PH_SEGWIT2)
        begin
            if (b == SEGWIT_FLAG)
            begin
                ps_phase = PH_NIN;
                used     = 1'b1;
            end
            else
            begin
                ps_inputs = '0;
                ps_phase  = PH_NOUT;
            end
        end

        if (!used)
        begin
            case (ps_phase)
                PH_VERSION:
                begin
                    ps_idx = ps_idx + 3'd1;
                    if (ps_idx == VERSION_BYTES)
                    begin
                        ps_idx   = '0;
                        ps_phase = PH_SEGWIT;
                    end
                end
                PH_NIN:
                begin
                    fed = cs_feed(b, v);
                    if (fed)
                    begin
                        if (v > COUNT_MAX)
                        begin
                            ps_phase = PH_FAIL;
                        end
                        else
                        begin
                            ps_inputs = v;
                            enter_inputs_or_outputs();
                        end
                    end
                end
                PH_INPREFIX:
                begin
                    ps_skip = ps_skip - 64'd1;
                    if (ps_skip == 64'd0)
                    begin
                        ps_phase = PH_SSLEN;
                    end
                end
                PH_SSLEN:
                begin
                    fed = cs_feed(b, v);
                    if (fed)
                    begin
                        ps_idx = '0;
                        if (v > COUNT_MAX)
                        begin
                            ps_phase = PH_FAIL;
                        end
                        else if (v == 64'd0)
                        begin
                            ps_phase = PH_SEQ;
                        end
                        else
                        begin
                            ps_skip  = v;
                            ps_phase = PH_SSSKIP;
                        end
                    end
                end
                PH_SSSKIP:
                begin
                    ps_skip = ps_skip - 64'd1;
                    if (ps_skip == 64'd0)
                    begin
                        ps_idx   = '0;
                        ps_phase = PH_SEQ;
                    end
                end
                PH_SEQ:
                begin
                    ps_idx = ps_idx + 3'd1;
                    if (ps_idx == SEQUENCE_BYTES)
                    begin
                        ps_idx    = '0;
                        ps_inputs = ps_inputs - 64'd1;
                        enter_inputs_or_outputs();
                    end
                end
                PH_NOUT:
                begin
                    fed = cs_feed(b, v);
                    if (fed)
                    begin
                        if (v == 64'd0)
                        begin
                            ps_phase = PH_FAIL;
                        end
                        else
                        begin
                            ps_idx   = '0;
                            ps_value = '0;
                            ps_phase = PH_VALUE;
                        end
                    end
                end
                PH_VALUE:
                begin
                    ps_value = ps_value | ({56'd0, b} << (8 * ps_idx));
                    if (ps_idx == VALUE_LAST_IDX)
                    begin
                        ps_idx   = '0;
                        ps_phase = PH_SPKLEN;
                    end
                    else
                    begin
                        ps_idx = ps_idx + 3'd1;
                    end
                end
                PH_SPKLEN:
                begin
                    fed = cs_feed(b, v);
                    if (fed)
                    begin
                        if (v > COUNT_MAX)
                        begin
                            ps_phase = PH_FAIL;
                        end
                        else
                        begin
                            ps_spk_len  = v;
                            ps_spk_left = v;
                            if (v == 64'd0)
                            begin
                                ps_ok    = 1'b1;
                                ps_phase = PH_DONE;
                            end
                            else
                            begin
                                ps_phase = PH_SPK;
                            end
                        end
                    end
                end
                PH_SPK:
                begin
                    has         = 1'b1;
                    ps_spk_left = ps_spk_left - 64'd1;
                    if (ps_spk_left == 64'd0)
                    begin
                        ps_ok    = 1'b1;
                        ps_phase = PH_DONE;
                    end
                end
                default:
                begin
                end
            endcase
        end

        emit         = has || fin;
        r.has_byte   = has;
        r.spk_byte   = has ? b : 8'd0;
        r.done_res   = fin;
        r.ok         = 1'b0;
        r.amount     = '0;
        r.spk_length = '0;
        if (fin)
        begin
            if (ps_ok)
            begin
                r.ok         = 1'b1;
                r.amount     = ps_value;
                r.spk_length = ps_spk_len[31:0];
            end
            else if (ps_phase == PH_SPKLEN)
            begin
                r.ok     = 1'b1;
                r.amount = ps_value;
            end
            clear_parser();
        end
    endfunction

    function automatic int gap_len();
        return ($urandom_range(0, 9) < 8) ? int'($urandom_range(1, 3))
                                          : int'($urandom_range(8, 40));
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        tx_bytes.insert(tx_bytes.size(), b);
    endfunction

    task automatic note_fail(input string msg);
        fails++;
        if (fails <= 10)
        begin
            $display("mismatch: %s", msg);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int   gap;
        bit   emit;
        res_t e;
        in_valid <= 1'b1;
        in_byte  <= b;
        last     <= fin;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        step_parser(b, fin, emit, e);
        if (emit)
        begin
            pending_words.insert(pending_words.size(), e);
        end
        sent_bytes++;
        gap = (!in_quiet && $urandom_range(0, 2) == 0) ? gap_len() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_tx();
        in_quiet = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < tx_bytes.size(); i++)
        begin
            send_byte(tx_bytes[i], i == tx_bytes.size() - 1);
        end
    endtask

    function automatic void push_cs(input logic [63:0] v);
        int min_form;
        int form;
        int nb;
        min_form = (v < 64'd253) ? 0 : (v < 64'h1_0000) ? 1 : (v < 64'h1_0000_0000) ? 2 : 3;
        form = ($urandom_range(0, 3) == 0) ? int'($urandom_range(min_form, 3)) : min_form;
        case (form)
            0:
            begin
                add_byte(v[7:0]);
                nb = 0;
            end
            1:
            begin
                add_byte(CS_U16);
                nb = 2;
            end
            2:
            begin
                add_byte(CS_U32);
                nb = 4;
            end
            default:
            begin
                add_byte(CS_U64);
                nb = 8;
            end
        endcase
        for (int i = 0; i < nb; i++)
        begin
            add_byte(v[8*i +: 8]);
        end
    endfunction

    function automatic logic [63:0] pick_count(input int hi, output bit stop);
        int k;
        k    = $urandom_range(0, 49);
        stop = (k < 3);
        case (k)
            0:       return {32'($urandom_range(1, 32'hFFFF_FFFF)), 32'($urandom)};
            1:       return COUNT_MAX;
            2:       return COUNT_MAX + 64'd1;
            default: return 64'($urandom_range(0, hi));
        endcase
    endfunction

    task automatic build_tx();
        logic [63:0] n_in;
        logic [63:0] ss_len;
        logic [63:0] s_len;
        bit          stop;
        int          sel;
        tx_bytes.delete();
        repeat (4) add_byte(8'($urandom));
        if ($urandom_range(0, 2) == 0)
        begin
            add_byte(SEGWIT_MARKER);
            add_byte(SEGWIT_FLAG);
        end
        n_in = pick_count(2, stop);
        push_cs(n_in);
        for (longint i = 0; i < longint'(n_in) && !stop; i++)
        begin
            repeat (PREFIX_BYTES) add_byte(8'($urandom));
            ss_len = pick_count(6, stop);
            push_cs(ss_len);
            if (!stop)
            begin
                repeat (int'(ss_len)) add_byte(8'($urandom));
                repeat (4) add_byte(8'($urandom));
            end
        end
        if (!stop)
        begin
            push_cs(($urandom_range(0, 9) == 0) ? 64'd0 : 64'($urandom_range(1, 3)));
            sel = $urandom_range(0, 9);
            repeat (8) add_byte((sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : 8'($urandom));
            s_len = pick_count(12, stop);
            push_cs(s_len);
            if (!stop)
            begin
                repeat (int'(s_len)) add_byte(8'($urandom));
            end
        end
        repeat ($urandom_range(0, stop ? 6 : 3)) add_byte(8'($urandom));
    endtask

    task automatic test_short_frames();
        tx_bytes = '{8'h00};
        send_tx();
        tx_bytes = '{8'h01, 8'h02, 8'h03, 8'h04, SEGWIT_MARKER};
        send_tx();
        tx_bytes = '{8'hFF, 8'h00, 8'h00, 8'hFF, SEGWIT_MARKER, 8'h00};
        send_tx();
    endtask

    task automatic test_empty_inputs();
        tx_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, SEGWIT_MARKER, 8'h02,
                     8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
        send_tx();
    endtask

    task automatic test_random_transactions();
        int target;
        int mode;
        int keep;
        target = sent_bytes + RANDOM_BYTES;
        while (sent_bytes < target)
        begin
            build_tx();
            mode = $urandom_range(0, 9);
            if (mode >= 6 && mode <= 8)
            begin
                keep = $urandom_range(1, tx_bytes.size());
                while (tx_bytes.size() > keep)
                begin
                    void'(tx_bytes.pop_back());
                end
            end
            else if (mode == 9)
            begin
                tx_bytes.delete();
                repeat ($urandom_range(1, 20)) add_byte(8'($urandom));
            end
            send_tx();
        end
    endtask

    initial
    begin
        int  hold_left;
        int  run_left;
        bit  out_quiet;
        out_stall = 1'b0;
        hold_left = 0;
        run_left  = 0;
        out_quiet = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (run_left == 0)
            begin
                out_quiet = ($urandom_range(0, 3) == 0);
                run_left  = $urandom_range(50, 300);
            end
            run_left--;
            if (hold_left != 0)
            begin
                hold_left--;
            end
            else if (!out_quiet && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                hold_left = gap_len() - 1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : check_words
        res_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_words.size() == 0)
            begin
                note_fail($sformatf("unexpected word has=%0d byte=%02h done=%0d ok=%0d",
                                    has_byte, spk_byte, done_res, ok));
            end
            else
            begin
                e = pending_words.pop_front();
                if (has_byte !== e.has_byte || spk_byte !== e.spk_byte ||
                    done_res !== e.done_res || ok !== e.ok ||
                    amount !== e.amount || spk_length !== e.spk_length)
                begin
                    note_fail($sformatf(
                        {"exp has=%0d byte=%02h done=%0d ok=%0d amt=%016h len=%08h",
                         " / got has=%0d byte=%02h done=%0d ok=%0d amt=%016h len=%08h"},
                        e.has_byte, e.spk_byte, e.done_res, e.ok, e.amount, e.spk_length,
                        has_byte, spk_byte, done_res, ok, amount, spk_length));
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("tb_tx_first_output_parser_core NOT OK");
        $finish;
    end

    initial
    begin
        in_valid   = 1'b0;
        in_byte    = 8'd0;
        last       = 1'b0;
        rst_n      = 1'b0;
        in_quiet   = 1'b0;
        fails      = 0;
        sent_bytes = 0;
        clear_parser();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_short_frames();
        test_empty_inputs();
        test_random_transactions();
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (fails == 0)
        begin
            $display("tb_tx_first_output_parser_core OK");
        end
        else
        begin
            $display("tb_tx_first_output_parser_core NOT OK");
        end
        $finish;
    end

endmodule
